### design/bif_pkg.sv
package bif_pkg;

   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_WINDOW_DEF = 7;

   localparam int CH_W       = 8;
   localparam int NUM_CH     = 3;
   localparam int NUM_LANES  = 4;
   localparam int SP_LANE    = 3;
   localparam int PIX_W      = NUM_CH * CH_W;
   localparam int DIM_W      = 12;
   localparam int ROW_W      = 12;
   localparam int WS_W       = 3;
   localparam int RS_W       = 24;
   localparam int CFG_IDX_W  = 2;
   localparam int CFG_DATA_W = 24;
   localparam int WGT_W      = 17;
   localparam int SUM_W      = 32;
   localparam int WSUM_W     = 24;
   localparam int D2_W       = 16;
   localparam int ARG_W      = 39;
   localparam int TEXP_W     = 40;
   localparam int RECIP_W    = 33;
   localparam int SPN_W      = 24;
   localparam int LOG2E_W    = 17;

   localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd2;
   localparam logic [CFG_IDX_W-1:0] REG_RANGE_SCALE  = 2'd3;

   localparam logic OP_PIXEL = 1'b0;

   localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = 12'd640;
   localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = 12'd480;
   localparam logic [WS_W-1:0]  WINDOW_SIZE_RST  = 3'd3;
   localparam logic [RS_W-1:0]  RANGE_SCALE_RST  = 24'd167772;

   // log2(e) in Q.16.
   localparam logic [LOG2E_W-1:0] LOG2E_Q16 = 17'd94548;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EVAL,
      S_CADDR,
      S_CDATA,
      S_TADDR,
      S_TDATA,
      S_TRX,
      S_TT,
      S_TV,
      S_TW,
      S_TACC,
      S_DIV,
      S_OUT
   } state_type;

   // 2^(-j/16) in Q0.16.
   function automatic logic [WGT_W-1:0] exp2_tab(input logic [4:0] j);
      logic [WGT_W-1:0] v;
      case (j)
         5'd0:    v = 17'd65536;
         5'd1:    v = 17'd62757;
         5'd2:    v = 17'd60097;
         5'd3:    v = 17'd57549;
         5'd4:    v = 17'd55109;
         5'd5:    v = 17'd52773;
         5'd6:    v = 17'd50535;
         5'd7:    v = 17'd48393;
         5'd8:    v = 17'd46341;
         5'd9:    v = 17'd44376;
         5'd10:   v = 17'd42495;
         5'd11:   v = 17'd40693;
         5'd12:   v = 17'd38968;
         5'd13:   v = 17'd37316;
         5'd14:   v = 17'd35734;
         5'd15:   v = 17'd34219;
         default: v = 17'd32768;
      endcase
      return v;
   endfunction

   // Rounded-up 2^32 / s^2, used to divide the spatial argument by s^2.
   function automatic logic [RECIP_W-1:0] spat_recip(input logic [WS_W-1:0] s);
      logic [RECIP_W-1:0] v;
      case (s)
         3'd2:    v = 33'd1073741824;
         3'd3:    v = 33'd477218589;
         3'd4:    v = 33'd268435456;
         3'd5:    v = 33'd171798692;
         3'd6:    v = 33'd119304648;
         3'd7:    v = 33'd87652394;
         default: v = 33'd4294967296;
      endcase
      return v;
   endfunction

endpackage

### design/bif_if.sv
interface bif_req_if;
   logic                     valid;
   logic                     ready;
   logic                     opcode;
   logic                     frame_start;
   logic [bif_pkg::CH_W-1:0] chan_a;
   logic [bif_pkg::CH_W-1:0] chan_b;
   logic [bif_pkg::CH_W-1:0] chan_c;

   modport source (output valid, opcode, frame_start, chan_a, chan_b, chan_c, input ready);
   modport sink (input valid, opcode, frame_start, chan_a, chan_b, chan_c, output ready);
endinterface

interface bif_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [bif_pkg::CH_W-1:0] out_a;
   logic [bif_pkg::CH_W-1:0] out_b;
   logic [bif_pkg::CH_W-1:0] out_c;
   logic                     was_filtered;
   logic                     frame_last;

   modport source (output valid, out_a, out_b, out_c, was_filtered, frame_last, input ready);
   modport sink (input valid, out_a, out_b, out_c, was_filtered, frame_last, output ready);
endinterface

interface bif_csr_if;
   logic                           valid;
   logic                           ready;
   logic [bif_pkg::CFG_IDX_W-1:0]  index;
   logic [bif_pkg::CFG_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### design/bif_ram.sv
module bif_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/bilateral_image_filter_core.sv
// Streaming bilateral filter for three-channel 8-bit pixels in row-major order.
// req carries one transaction per pixel (opcode pixel) or a flush (opcode flush)
// that only drains pending output; frame_start on a pixel restarts the frame.
// rsp returns at most one filtered pixel per req transaction, in row-major order,
// once the pixel's whole window has arrived; border pixels pass through.
// csr writes image_width, image_height, window_size and range_scale by index;
// it is always ready. The user must ensure it is written only while no
// transaction is in flight; the block does not enforce this. A req transaction
// is taken only when the engine is idle. Each tap of a filtered pixel passes
// through the shared exp lanes: address, data, range argument, exponent, weight,
// product, accumulate; a restoring division then yields the result. The tap loop
// sets the rate. The line store is a single-port-read memory of MAX_WINDOW rows;
// its reads are registered. Reset restores register defaults and clears all
// positions. The output register holds a result until rsp.ready; a stalled rsp
// only blocks the engine when the next result is ready to be loaded.
module bilateral_image_filter_core #(
   parameter int MAX_WIDTH  = bif_pkg::MAX_WIDTH_DEF,
   parameter int MAX_WINDOW = bif_pkg::MAX_WINDOW_DEF
) (
   input logic       clock,
   input logic       reset,
   bif_req_if.sink   req,
   bif_rsp_if.source rsp,
   bif_csr_if.sink   csr
);

   localparam int COL_W  = $clog2(MAX_WIDTH + 1);
   localparam int SLOT_W = $clog2(MAX_WINDOW);
   localparam int DEPTH  = MAX_WINDOW * MAX_WIDTH;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = bif_pkg::ROW_W + COL_W;
   localparam int NCH    = bif_pkg::NUM_CH;
   localparam int NLN    = bif_pkg::NUM_LANES;
   localparam int SP     = bif_pkg::SP_LANE;
   localparam int CW     = bif_pkg::CH_W;
   localparam int WGT_W  = bif_pkg::WGT_W;
   localparam int SUM_W  = bif_pkg::SUM_W;
   localparam int ARG_W  = bif_pkg::ARG_W;
   localparam int TEXP_W = bif_pkg::TEXP_W;
   localparam int SPP_W  = bif_pkg::SPN_W + bif_pkg::RECIP_W;
   localparam int ROW_W  = bif_pkg::ROW_W;

   function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
      return (s == SLOT_W'(MAX_WINDOW - 1)) ? '0 : s + 1'b1;
   endfunction

   function automatic logic [ADDR_W-1:0] slot_base(input logic [SLOT_W-1:0] s);
      return ADDR_W'(s) * ADDR_W'(MAX_WIDTH);
   endfunction

   // Configuration registers.
   logic [bif_pkg::DIM_W-1:0] image_width_ff, image_height_ff;
   logic [bif_pkg::WS_W-1:0]  window_size_ff;
   logic [bif_pkg::RS_W-1:0]  range_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= bif_pkg::IMAGE_WIDTH_RST;
         image_height_ff <= bif_pkg::IMAGE_HEIGHT_RST;
         window_size_ff  <= bif_pkg::WINDOW_SIZE_RST;
         range_scale_ff  <= bif_pkg::RANGE_SCALE_RST;
      end else if (csr.valid) begin
         case (csr.index)
            bif_pkg::REG_IMAGE_WIDTH:  image_width_ff  <= csr.data[bif_pkg::DIM_W-1:0];
            bif_pkg::REG_IMAGE_HEIGHT: image_height_ff <= csr.data[bif_pkg::DIM_W-1:0];
            bif_pkg::REG_WINDOW_SIZE:  window_size_ff  <= csr.data[bif_pkg::WS_W-1:0];
            bif_pkg::REG_RANGE_SCALE:  range_scale_ff  <= csr.data[bif_pkg::RS_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr.ready = 1'b1;

   // Effective geometry after clamping.
   logic [COL_W-1:0] w_eff;
   logic [ROW_W-1:0] h_eff;
   logic [2:0]       s_eff, lo, hi;
   logic [5:0]       s_sq;

   always_comb begin
      if (image_width_ff < 12'd3) begin
         w_eff = COL_W'(3);
      end else if (int'(image_width_ff) > MAX_WIDTH) begin
         w_eff = COL_W'(MAX_WIDTH);
      end else begin
         w_eff = COL_W'(image_width_ff);
      end
      h_eff = (image_height_ff < 12'd3) ? 12'd3 : image_height_ff;
      if (window_size_ff == 3'd0) begin
         s_eff = 3'd1;
      end else if (int'(window_size_ff) > MAX_WINDOW) begin
         s_eff = 3'(MAX_WINDOW);
      end else begin
         s_eff = window_size_ff;
      end
      lo   = s_eff >> 1;
      hi   = s_eff - 3'd1 - lo;
      s_sq = 6'(s_eff) * 6'(s_eff);
   end

   logic [CNT_W-1:0] total_ff, hiw_ff;

   always_ff @(posedge clock) begin
      total_ff <= CNT_W'(w_eff) * CNT_W'(h_eff);
      hiw_ff   <= CNT_W'(hi) * CNT_W'(w_eff);
   end

   // Control state.
   bif_pkg::state_type state_ff, state_in;
   logic [COL_W-1:0]  in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_W-1:0]  in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [SLOT_W-1:0] in_slot_ff, in_slot_in, out_slot_ff, out_slot_in;
   logic [CNT_W-1:0]  in_cnt_ff, in_cnt_in, out_idx_ff, out_idx_in;
   logic [2:0]        tx_ff, ty_ff, div_step_ff;
   logic              rsp_valid_ff;

   logic              req_accept, rsp_load, rsp_free, tap_last;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr, center_addr, tap_addr;
   logic [bif_pkg::PIX_W-1:0] rd_data;

   assign req.ready  = (state_ff == bif_pkg::S_IDLE);
   assign req_accept = req.valid && req.ready;
   assign rsp_free   = !rsp_valid_ff || rsp.ready;
   assign rsp_load   = (state_ff == bif_pkg::S_OUT) && rsp_free;
   assign tap_last   = (tx_ff == s_eff - 3'd1) && (ty_ff == s_eff - 3'd1);

   bif_ram #(
      .WIDTH (bif_pkg::PIX_W),
      .DEPTH (DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req.chan_c, req.chan_b, req.chan_a}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Write position, output position and store write.
   always_comb begin
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      in_slot_in  = in_slot_ff;
      in_cnt_in   = in_cnt_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_slot_in = out_slot_ff;
      out_idx_in  = out_idx_ff;
      wr_en       = 1'b0;
      wr_addr     = '0;
      if (req_accept && req.opcode == bif_pkg::OP_PIXEL) begin
         if (req.frame_start) begin
            in_col_in   = '0;
            in_row_in   = '0;
            in_slot_in  = '0;
            in_cnt_in   = '0;
            out_col_in  = '0;
            out_row_in  = '0;
            out_slot_in = '0;
            out_idx_in  = '0;
         end
         // A column left beyond a narrowed width moves to the next row.
         if (in_row_in < h_eff && in_col_in >= w_eff) begin
            in_col_in  = '0;
            in_row_in  = in_row_in + 12'd1;
            in_slot_in = slot_next(in_slot_in);
         end
         if (in_row_in < h_eff) begin
            wr_en     = 1'b1;
            wr_addr   = slot_base(in_slot_in) + ADDR_W'(in_col_in);
            in_col_in = in_col_in + 1'b1;
            in_cnt_in = in_cnt_in + 1'b1;
            if (in_col_in >= w_eff) begin
               in_col_in  = '0;
               in_row_in  = in_row_in + 12'd1;
               in_slot_in = slot_next(in_slot_in);
            end
         end
      end
      if (rsp_load) begin
         out_idx_in = out_idx_ff + 1'b1;
         if (out_col_ff + 1'b1 >= w_eff) begin
            out_col_in  = '0;
            out_row_in  = out_row_ff + 12'd1;
            out_slot_in = slot_next(out_slot_ff);
         end else begin
            out_col_in = out_col_ff + 1'b1;
         end
      end
   end

   // Emission test and border test.
   logic [CNT_W-1:0] got;
   logic             emit_ok, border, border_ff;

   always_comb begin
      got     = (in_row_ff >= h_eff) ? total_ff : in_cnt_ff;
      emit_ok = (out_idx_ff < total_ff) &&
                ((({1'b0, out_idx_ff} + {1'b0, hiw_ff} + (CNT_W + 1)'(hi)) < {1'b0, got}) ||
                 (got >= total_ff));
      border  = (out_row_ff < ROW_W'(lo)) ||
                (({1'b0, out_row_ff} + (ROW_W + 1)'(hi)) > ({1'b0, h_eff} - 13'd1)) ||
                (out_col_ff < COL_W'(lo)) ||
                (({1'b0, out_col_ff} + (COL_W + 1)'(hi)) > ({1'b0, w_eff} - (COL_W + 1)'(1)));
   end

   // Tap addressing: row slot is (out_slot + ty - lo) mod MAX_WINDOW.
   logic [SLOT_W+1:0] slot_sum;
   logic [SLOT_W-1:0] tap_slot;
   logic [COL_W-1:0]  tap_col;
   logic [2:0]        dx, dy;
   logic [4:0]        dist2;

   always_comb begin
      slot_sum = (SLOT_W + 2)'(out_slot_ff) + (SLOT_W + 2)'(ty_ff) +
                 (SLOT_W + 2)'(MAX_WINDOW) - (SLOT_W + 2)'(lo);
      if (slot_sum >= (SLOT_W + 2)'(MAX_WINDOW)) begin
         slot_sum = slot_sum - (SLOT_W + 2)'(MAX_WINDOW);
      end
      if (slot_sum >= (SLOT_W + 2)'(MAX_WINDOW)) begin
         slot_sum = slot_sum - (SLOT_W + 2)'(MAX_WINDOW);
      end
      tap_slot    = SLOT_W'(slot_sum);
      tap_col     = out_col_ff + COL_W'(tx_ff) - COL_W'(lo);
      tap_addr    = slot_base(tap_slot) + ADDR_W'(tap_col);
      center_addr = slot_base(out_slot_ff) + ADDR_W'(out_col_ff);
      dx          = (tx_ff >= lo) ? tx_ff - lo : lo - tx_ff;
      dy          = (ty_ff >= lo) ? ty_ff - lo : lo - ty_ff;
      dist2       = 5'(dx) * 5'(dx) + 5'(dy) * 5'(dy);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      rd_addr  = center_addr;
      case (state_ff)
         bif_pkg::S_IDLE: begin
            if (req.valid) begin
               state_in = bif_pkg::S_EVAL;
            end
         end
         bif_pkg::S_EVAL:  state_in = emit_ok ? bif_pkg::S_CADDR : bif_pkg::S_IDLE;
         bif_pkg::S_CADDR: state_in = bif_pkg::S_CDATA;
         bif_pkg::S_CDATA: state_in = border_ff ? bif_pkg::S_OUT : bif_pkg::S_TADDR;
         bif_pkg::S_TADDR: begin
            rd_addr  = tap_addr;
            state_in = bif_pkg::S_TDATA;
         end
         bif_pkg::S_TDATA: state_in = bif_pkg::S_TRX;
         bif_pkg::S_TRX:   state_in = bif_pkg::S_TT;
         bif_pkg::S_TT:    state_in = bif_pkg::S_TV;
         bif_pkg::S_TV:    state_in = bif_pkg::S_TW;
         bif_pkg::S_TW:    state_in = bif_pkg::S_TACC;
         bif_pkg::S_TACC:  state_in = tap_last ? bif_pkg::S_DIV : bif_pkg::S_TADDR;
         bif_pkg::S_DIV: begin
            if (div_step_ff == 3'd0) begin
               state_in = bif_pkg::S_OUT;
            end
         end
         bif_pkg::S_OUT: begin
            if (rsp_free) begin
               state_in = bif_pkg::S_IDLE;
            end
         end
         default: state_in = bif_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bif_pkg::S_IDLE;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         in_slot_ff   <= '0;
         in_cnt_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         out_slot_ff  <= '0;
         out_idx_ff   <= '0;
         tx_ff        <= '0;
         ty_ff        <= '0;
         div_step_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         in_slot_ff  <= in_slot_in;
         in_cnt_ff   <= in_cnt_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         out_slot_ff <= out_slot_in;
         out_idx_ff  <= out_idx_in;
         if (state_ff == bif_pkg::S_CDATA) begin
            tx_ff <= '0;
            ty_ff <= '0;
         end else if (state_ff == bif_pkg::S_TACC) begin
            if (tx_ff == s_eff - 3'd1) begin
               tx_ff <= '0;
               ty_ff <= ty_ff + 3'd1;
            end else begin
               tx_ff <= tx_ff + 3'd1;
            end
         end
         if (state_ff == bif_pkg::S_TACC) begin
            div_step_ff <= 3'd7;
         end else if (state_ff == bif_pkg::S_DIV) begin
            div_step_ff <= div_step_ff - 3'd1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath: three range lanes and one spatial lane share the exp stages.
   logic [bif_pkg::PIX_W-1:0] center_ff;
   logic [SPP_W-1:0]          sp_prod_ff;
   logic [bif_pkg::SPN_W-1:0] sp_n_ff;
   logic [bif_pkg::SPN_W:0]   sp_qest;
   logic [bif_pkg::SPN_W-1:0] sp_q;
   logic [30:0]               sp_check;
   logic [CW-1:0]             pv_ff [NCH];
   logic [CW-1:0]             pv_in [NCH];
   logic [bif_pkg::D2_W-1:0]  d2_ff [NCH];
   logic [bif_pkg::D2_W-1:0]  d2_in [NCH];
   logic [CW-1:0]             dd    [NCH];
   logic [ARG_W-1:0]          x_ff  [NLN];
   logic [ARG_W-1:0]          rx_in [NCH];
   logic [TEXP_W-1:0]         t_ff  [NLN];
   logic [TEXP_W-1:0]         t_in  [NLN];
   logic [WGT_W-1:0]          w_ff  [NLN];
   logic [WGT_W-1:0]          w_in  [NLN];
   logic [WGT_W-1:0]          tj    [NLN];
   logic [WGT_W-1:0]          tj1   [NLN];
   logic [32:0]               ip    [NLN];
   logic [WGT_W-1:0]          wt_ff [NCH];
   logic [WGT_W-1:0]          wt_in [NCH];
   logic [SUM_W-1:0]          sum_ff [NCH];
   logic [bif_pkg::WSUM_W-1:0] wsum_ff [NCH];
   logic [SUM_W-1:0]          trial [NCH];
   logic [CW-1:0]             res_ff [NCH];

   always_comb begin
      sp_qest  = sp_prod_ff[SPP_W-1:32];
      sp_check = 31'(sp_qest) * 31'(s_sq);
      sp_q     = (sp_check > 31'(sp_n_ff)) ? bif_pkg::SPN_W'(sp_qest - 1'b1)
                                           : bif_pkg::SPN_W'(sp_qest);
      for (int c = 0; c < NCH; c++) begin
         pv_in[c] = rd_data[CW*c +: CW];
         dd[c]    = (pv_in[c] > center_ff[CW*c +: CW]) ? pv_in[c] - center_ff[CW*c +: CW]
                                                       : center_ff[CW*c +: CW] - pv_in[c];
         d2_in[c] = bif_pkg::D2_W'(dd[c]) * bif_pkg::D2_W'(dd[c]);
         rx_in[c] = ARG_W'((40'(d2_ff[c]) * 40'(range_scale_ff)) >> 1);
         wt_in[c] = WGT_W'((34'(w_ff[c]) * 34'(w_ff[SP])) >> 16);
         trial[c] = SUM_W'(wsum_ff[c]) << div_step_ff;
      end
      // exp(-x) = 2^(-x*log2 e), interpolated between sixteenth steps.
      for (int l = 0; l < NLN; l++) begin
         t_in[l] = TEXP_W'((56'(x_ff[l]) * 56'(bif_pkg::LOG2E_Q16)) >> 16);
         tj[l]   = bif_pkg::exp2_tab({1'b0, t_ff[l][19:16]});
         tj1[l]  = bif_pkg::exp2_tab(5'(t_ff[l][19:16]) + 5'd1);
         ip[l]   = 33'(tj[l] - tj1[l]) * 33'(t_ff[l][15:0]);
         if (t_ff[l][TEXP_W-1:20] >= 20'd17) begin
            w_in[l] = '0;
         end else begin
            w_in[l] = (tj[l] - ip[l][32:16]) >> t_ff[l][24:20];
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         bif_pkg::S_EVAL: border_ff <= border;
         bif_pkg::S_CDATA: begin
            center_ff <= rd_data;
            for (int c = 0; c < NCH; c++) begin
               res_ff[c]  <= border_ff ? rd_data[CW*c +: CW] : '0;
               sum_ff[c]  <= '0;
               wsum_ff[c] <= '0;
            end
         end
         bif_pkg::S_TADDR: begin
            sp_n_ff    <= bif_pkg::SPN_W'(dist2) << 19;
            sp_prod_ff <= (SPP_W'(dist2) << 19) * SPP_W'(bif_pkg::spat_recip(s_eff));
         end
         bif_pkg::S_TDATA: begin
            for (int c = 0; c < NCH; c++) begin
               pv_ff[c] <= pv_in[c];
               d2_ff[c] <= d2_in[c];
            end
            x_ff[SP] <= ARG_W'(sp_q);
         end
         bif_pkg::S_TRX: begin
            for (int c = 0; c < NCH; c++) begin
               x_ff[c] <= rx_in[c];
            end
         end
         bif_pkg::S_TT: t_ff <= t_in;
         bif_pkg::S_TV: w_ff <= w_in;
         bif_pkg::S_TW: wt_ff <= wt_in;
         bif_pkg::S_TACC: begin
            for (int c = 0; c < NCH; c++) begin
               sum_ff[c]  <= sum_ff[c] + SUM_W'(wt_ff[c]) * SUM_W'(pv_ff[c]);
               wsum_ff[c] <= wsum_ff[c] + bif_pkg::WSUM_W'(wt_ff[c]);
            end
         end
         bif_pkg::S_DIV: begin
            for (int c = 0; c < NCH; c++) begin
               if (sum_ff[c] >= trial[c]) begin
                  sum_ff[c]              <= sum_ff[c] - trial[c];
                  res_ff[c][div_step_ff] <= 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   // Output register.
   logic [CW-1:0] out_a_ff, out_b_ff, out_c_ff;
   logic          was_filtered_ff, frame_last_ff;

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         out_a_ff        <= res_ff[0];
         out_b_ff        <= res_ff[1];
         out_c_ff        <= res_ff[2];
         was_filtered_ff <= !border_ff;
         frame_last_ff   <= (out_idx_ff == total_ff - 1'b1);
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.out_a        = out_a_ff;
   assign rsp.out_b        = out_b_ff;
   assign rsp.out_c        = out_c_ff;
   assign rsp.was_filtered = was_filtered_ff;
   assign rsp.frame_last   = frame_last_ff;

   // The center tap always weighs one, so no channel divides by zero.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == bif_pkg::S_DIV |-> wsum_ff[0] != 0 && wsum_ff[1] != 0 && wsum_ff[2] != 0)
      else $error("zero weight sum at division");

   // The remainder stays below the divisor shifted past the current quotient bit.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == bif_pkg::S_DIV |->
         sum_ff[0] < ((SUM_W'(wsum_ff[0]) << div_step_ff) << 1) &&
         sum_ff[1] < ((SUM_W'(wsum_ff[1]) << div_step_ff) << 1) &&
         sum_ff[2] < ((SUM_W'(wsum_ff[2]) << div_step_ff) << 1))
      else $error("quotient overflow in divider");

   assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> out_idx_ff == $past(out_idx_ff) + 1'b1)
      else $error("output index did not advance with a result");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == bif_pkg::S_TADDR |-> tx_ff < s_eff && ty_ff < s_eff)
      else $error("tap counter outside window");

endmodule

### tb/bif_checker.sv
`timescale 1ns / 100ps

module bif_checker
   import bif_pkg::*;
(
   input  logic clock,
   input  logic reset,
   bif_req_if   req,
   bif_rsp_if   rsp,
   bif_csr_if   csr,
   output int   errors,
   output int   pending
);

   typedef struct {
      logic [CH_W-1:0] a;
      logic [CH_W-1:0] b;
      logic [CH_W-1:0] c;
      logic            filt;
      logic            last;
   } pix_result_t;

   // 2^(-j/16) in Q0.16, one entry past the end for the interpolation.
   localparam longint unsigned POW2_FRAC [17] = '{
      65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
      44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768
   };

   int unsigned  cfg_w, cfg_h, cfg_s, cfg_rs;
   logic [PIX_W-1:0] line_mem [0:MAX_WINDOW_DEF*MAX_WIDTH_DEF-1];
   int unsigned  col_pos, row_pos, emit_pos;
   pix_result_t  expected_px [$];

   function automatic int unsigned eff_width();
      if (cfg_w < 3) return 3;
      if (cfg_w > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
      return cfg_w;
   endfunction

   function automatic int unsigned eff_height();
      return (cfg_h < 3) ? 3 : cfg_h;
   endfunction

   function automatic int unsigned eff_side();
      if (cfg_s == 0) return 1;
      if (cfg_s > MAX_WINDOW_DEF) return MAX_WINDOW_DEF;
      return cfg_s;
   endfunction

   function automatic logic [PIX_W-1:0] line_at(input int unsigned r, input int unsigned c);
      return line_mem[(r % MAX_WINDOW_DEF) * MAX_WIDTH_DEF + (c % MAX_WIDTH_DEF)];
   endfunction

   // exp(-x) for x in Q.20, result in Q0.16, through 2^(-x*log2 e).
   function automatic longint unsigned neg_exp(input longint unsigned x);
      longint unsigned t, k, v, j, r;
      t = (x * LOG2E_Q16) >> 16;
      k = t >> 20;
      j = (t & 64'hFFFFF) >> 16;
      r = t & 64'hFFFF;
      if (k >= 17) return 0;
      v = POW2_FRAC[j] - (((POW2_FRAC[j] - POW2_FRAC[j+1]) * r) >> 16);
      return v >> k;
   endfunction

   function automatic logic [CH_W-1:0] filter_chan(input int unsigned ro, input int unsigned co,
                                                   input int unsigned s, input int unsigned ch);
      longint unsigned acc, wacc, ws, wr, wt, cv, pv, dx, dy, d;
      int unsigned lo;
      lo   = s / 2;
      acc  = 0;
      wacc = 0;
      cv   = (line_at(ro, co) >> (8 * ch)) & 8'hFF;
      for (int unsigned y = 0; y < s; y++) begin
         for (int unsigned x = 0; x < s; x++) begin
            pv = (line_at(ro + y - lo, co + x - lo) >> (8 * ch)) & 8'hFF;
            dy = (y > lo) ? y - lo : lo - y;
            dx = (x > lo) ? x - lo : lo - x;
            d  = (pv > cv) ? pv - cv : cv - pv;
            ws = neg_exp(((dx * dx + dy * dy) << 19) / (s * s));
            wr = neg_exp((d * d * cfg_rs) >> 1);
            wt = (ws * wr) >> 16;
            acc  += wt * pv;
            wacc += wt;
         end
      end
      return (acc / wacc) & 8'hFF;
   endfunction

   // Advances the stream position for one transaction and returns 1 when a
   // filtered or passed pixel leaves on it.
   function automatic bit predict_step(input logic op, input logic fs,
                                       input logic [PIX_W-1:0] px, output pix_result_t res);
      int unsigned w, h, s, lo, hi, total, got, ro, co;
      logic [PIX_W-1:0] ctr;
      w = eff_width();
      h = eff_height();
      s = eff_side();
      res = '{default: '0};
      if (op == OP_PIXEL) begin
         if (fs) begin
            col_pos  = 0;
            row_pos  = 0;
            emit_pos = 0;
         end
         if (row_pos < h && col_pos >= w) begin
            col_pos = 0;
            row_pos++;
         end
         if (row_pos < h) begin
            line_mem[(row_pos % MAX_WINDOW_DEF) * MAX_WIDTH_DEF + col_pos] = px;
            col_pos++;
            if (col_pos >= w) begin
               col_pos = 0;
               row_pos++;
            end
         end
      end
      lo    = s / 2;
      hi    = s - 1 - s / 2;
      total = w * h;
      got   = (row_pos >= h) ? total : row_pos * w + col_pos;
      if (emit_pos >= total) return 0;
      if (!(emit_pos + hi * w + hi < got || got >= total)) return 0;
      ro  = emit_pos / w;
      co  = emit_pos % w;
      ctr = line_at(ro, co);
      if (ro < lo || ro + hi > h - 1 || co < lo || co + hi > w - 1) begin
         res.a = ctr[7:0];
         res.b = ctr[15:8];
         res.c = ctr[23:16];
         res.filt = 1'b0;
      end else begin
         res.a = filter_chan(ro, co, s, 0);
         res.b = filter_chan(ro, co, s, 1);
         res.c = filter_chan(ro, co, s, 2);
         res.filt = 1'b1;
      end
      res.last = (emit_pos == total - 1);
      emit_pos++;
      return 1;
   endfunction

   initial begin
      errors  = 0;
      pending = 0;
      foreach (line_mem[i]) line_mem[i] = '0;
   end

   always @(posedge clock) begin
      pix_result_t res, want;
      if (reset) begin
         cfg_w    = IMAGE_WIDTH_RST;
         cfg_h    = IMAGE_HEIGHT_RST;
         cfg_s    = WINDOW_SIZE_RST;
         cfg_rs   = RANGE_SCALE_RST;
         col_pos  = 0;
         row_pos  = 0;
         emit_pos = 0;
         expected_px.delete();
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr.index)
               REG_IMAGE_WIDTH:  cfg_w  = csr.data[DIM_W-1:0];
               REG_IMAGE_HEIGHT: cfg_h  = csr.data[DIM_W-1:0];
               REG_WINDOW_SIZE:  cfg_s  = csr.data[WS_W-1:0];
               REG_RANGE_SCALE:  cfg_rs = csr.data[RS_W-1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            if (predict_step(req.opcode, req.frame_start,
                             {req.chan_c, req.chan_b, req.chan_a}, res))
               expected_px.push_back(res);
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_px.size() == 0) begin
               if (errors < 10)
                  $display("%0t: unexpected result a=%0d b=%0d c=%0d", $realtime,
                           rsp.out_a, rsp.out_b, rsp.out_c);
               errors++;
            end else begin
               want = expected_px.pop_front();
               if (rsp.out_a !== want.a || rsp.out_b !== want.b || rsp.out_c !== want.c ||
                   rsp.was_filtered !== want.filt || rsp.frame_last !== want.last) begin
                  if (errors < 10)
                     $display("%0t: mismatch exp a=%0d b=%0d c=%0d f=%0b l=%0b got a=%0d b=%0d c=%0d f=%0b l=%0b",
                              $realtime, want.a, want.b, want.c, want.filt, want.last,
                              rsp.out_a, rsp.out_b, rsp.out_c, rsp.was_filtered, rsp.frame_last);
                  errors++;
               end
            end
         end
      end
      pending = expected_px.size();
   end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import bif_pkg::*;

   localparam logic OP_FLUSH     = 1'b1;
   localparam int   TARGET_ITEMS = 1550;
   localparam int   IDLE_LIMIT   = 20000;

   logic clock;
   logic reset;
   int   errors;
   int   pending;
   int   items_sent;
   int   burst_left;
   int   idle_cycles;
   int   stall_mode;
   int   cycle_cnt;
   int unsigned cur_w, cur_h, cur_s;

   bif_req_if req_ch ();
   bif_rsp_if rsp_ch ();
   bif_csr_if csr_ch ();

   bilateral_image_filter_core DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   bif_checker checker_i (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .csr     (csr_ch),
      .errors  (errors),
      .pending (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver changes its stall behavior at random among four modes.
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt % 300 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0:       rsp_ch.ready <= 1'b1;
         1:       rsp_ch.ready <= $urandom_range(0, 1);
         2:       rsp_ch.ready <= ($urandom_range(0, 7) == 0);
         default: rsp_ch.ready <= ($urandom_range(0, 5) != 0);
      endcase
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_req(input logic op, input logic fs, input logic [PIX_W-1:0] px);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid       <= 1'b1;
      req_ch.opcode      <= op;
      req_ch.frame_start <= fs;
      req_ch.chan_a      <= px[7:0];
      req_ch.chan_b      <= px[15:8];
      req_ch.chan_c      <= px[23:16];
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   // Waits until every predicted pixel has come back; a flush without result
   // may still be in the engine then, so the task idles on before it returns.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic configure(input int unsigned w, input int unsigned h, input int unsigned s,
                            input int unsigned rs);
      drain();
      csr_write(REG_IMAGE_WIDTH, w);
      csr_write(REG_IMAGE_HEIGHT, h);
      csr_write(REG_WINDOW_SIZE, s);
      csr_write(REG_RANGE_SCALE, rs);
      cur_w = (w < 3) ? 3 : ((w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w);
      cur_h = (h < 3) ? 3 : h;
      cur_s = (s == 0) ? 1 : s;
   endtask

   function automatic logic [CH_W-1:0] pick_chan(input logic [CH_W-1:0] base);
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 255);
         1:       return ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
         default: return base + 8'($urandom_range(0, 16)) - 8'd8;
      endcase
   endfunction

   function automatic logic [PIX_W-1:0] pick_pixel(input logic [CH_W-1:0] base);
      return {pick_chan(base), pick_chan(base), pick_chan(base)};
   endfunction

   task automatic random_frame();
      int unsigned npix, hi, extra;
      logic [CH_W-1:0] base;
      bit broken;
      base   = $urandom_range(0, 255);
      broken = ($urandom_range(0, 6) == 0);
      npix   = cur_w * cur_h;
      if (broken) npix = $urandom_range(1, npix - 1);
      hi = cur_s - 1 - cur_s / 2;
      for (int unsigned i = 0; i < npix; i++) begin
         if ($urandom_range(0, 11) == 0)
            send_req(OP_FLUSH, $urandom_range(0, 1), $urandom);
         send_req(OP_PIXEL, i == 0, pick_pixel(base));
      end
      if (broken) return;
      // Pixels after a complete frame are ignored but still drain like a flush.
      extra = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
      repeat (extra) send_req(OP_PIXEL, 1'b0, pick_pixel(base));
      repeat (hi * cur_w + hi + $urandom_range(1, 3))
         send_req(OP_FLUSH, $urandom_range(0, 1), $urandom);
   endtask

   task automatic random_config();
      int unsigned w, h, s, rs;
      w = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
      h = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      s = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 7) : $urandom_range(2, 4);
      case ($urandom_range(0, 5))
         0:       rs = 0;
         1:       rs = 24'hFFFFFF;
         2:       rs = $urandom_range(0, 24'hFFFFFF);
         default: rs = $urandom_range(1000, 400000);
      endcase
      configure(w, h, s, rs);
   endtask

   initial begin
      reset              = 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.opcode      <= OP_PIXEL;
      req_ch.frame_start <= 1'b0;
      req_ch.chan_a      <= '0;
      req_ch.chan_b      <= '0;
      req_ch.chan_c      <= '0;
      csr_ch.valid       <= 1'b0;
      csr_ch.index       <= REG_IMAGE_WIDTH;
      csr_ch.data        <= '0;
      rsp_ch.ready       = 1'b0;
      cycle_cnt          = 0;
      stall_mode         = 0;
      idle_cycles        = 0;
      items_sent         = 0;
      burst_left         = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Smallest image, no range falloff, extreme pixel values.
      configure(3, 3, 3, 0);
      for (int i = 0; i < 9; i++) begin
         if (i == 4) send_req(OP_FLUSH, 1'b1, 24'hFFFFFF);
         send_req(OP_PIXEL, i == 0, (i % 2) ? 24'hFFFFFF : 24'h000000);
      end
      send_req(OP_PIXEL, 1'b0, 24'h123456);
      send_req(OP_FLUSH, 1'b0, 24'h0);
      send_req(OP_FLUSH, 1'b0, 24'h0);

      // The widest width clamps and the height is left as set; a partial frame yields nothing.
      configure(12'hFFF, 12'hFFF, 7, 24'hFFFFFF);
      for (int i = 0; i < 4; i++) send_req(OP_PIXEL, i == 0, $urandom);

      // Registers below their range act as the minimum values.
      configure(0, 0, 0, 24'hFFFFFF);
      for (int i = 0; i < 9; i++) send_req(OP_PIXEL, i == 0, $urandom);
      send_req(OP_FLUSH, 1'b0, 24'h0);

      configure(7, 7, 7, 167772);
      random_frame();

      while (items_sent < TARGET_ITEMS) begin
         if ($urandom_range(0, 2) == 0) random_config();
         random_frame();
      end

      drain();
      repeat (50) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
